[sv/arp_pkg.sv]
// ----------------------------------------------------------------------------
// arp_pkg
// Shared widths, limits and register codes for the peak-to-peak RMS estimator.
// ----------------------------------------------------------------------------
package arp_pkg;

  // fixed field widths
  localparam int WS_W   = 8;   // window_samples
  localparam int WC_W   = 5;   // window_count
  localparam int GAIN_W = 18;  // rms_gain, Q16
  localparam int SUM_W  = 14;  // peak_sum
  localparam int RMS_W  = 16;  // rms_centivolts
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  // saturation limits and reset values
  localparam logic [SUM_W-1:0]  ACC_MAX = '1;
  localparam logic [RMS_W-1:0]  RMS_MAX = '1;
  localparam logic [WS_W-1:0]   WS_RESET   = WS_W'(200);
  localparam logic [WC_W-1:0]   WC_RESET   = WC_W'(10);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(234057);

  // fraction bits of the Q16 gain
  localparam int FRAC_BITS = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SAMPLES = 2'd0,
    REG_WINDOW_COUNT   = 2'd1,
    REG_RMS_GAIN       = 2'd2
  } cfg_reg_e;

endpackage

[sv/arp_if.sv]
// ----------------------------------------------------------------------------
// arp_if
// Valid/ready channels of the peak-to-peak RMS estimator: ADC samples,
// estimates and configuration writes.
// ----------------------------------------------------------------------------

// ADC sample stream
interface arp_sample_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// RMS estimate stream
interface arp_result_if
  import arp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms_centivolts;
  logic [SUM_W-1:0] peak_sum;

  modport source (output valid, output rms_centivolts, output peak_sum, input ready);
  modport sink   (input valid, input rms_centivolts, input peak_sum, output ready);
endinterface

// configuration write channel
interface arp_cfg_if
  import arp_pkg::*;
;
  logic                  valid;
  logic                  ready;
  cfg_reg_e              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/ac_rms_from_peak_to_peak.sv]
// ----------------------------------------------------------------------------
// ac_rms_from_peak_to_peak
// Windowed min/max tracker that sums peak-to-peak values over several windows
// and scales the sum by a Q16 gain into an RMS estimate in centivolts.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                      | word accepted when
//  ---------+-----+------------------------------+----------------------------
//  adc      | in  | sample                       | adc.valid & adc.ready
//  estimate | out | rms_centivolts, peak_sum     | estimate.valid & estimate.ready
//  cfg      | in  | index, data                  | cfg.valid & cfg.ready (always 1)
//
//  One sample per cycle. The window/accumulate update is done in the cycle a
//  sample is taken; a finished sum sits in a hold register, then the
//  Q16 multiply, rounding and saturation fill the output register.
//  adc.ready drops only while both the hold and output registers are full and
//  the output is stalled. Synchronous reset clears the window state and both
//  output stages and reloads the register defaults.
// ----------------------------------------------------------------------------
module ac_rms_from_peak_to_peak
  import arp_pkg::*;
#(
  parameter int ADC_BITS    = 10,
  parameter int MAX_WINDOWS = 16
) (
  input  logic          clk,
  input  logic          rst,
  arp_sample_if.sink    adc,
  arp_result_if.source  estimate,
  arp_cfg_if.sink       cfg
);

  // widths for comparisons and the sum
  localparam int MW_BITS = $clog2(MAX_WINDOWS + 1);
  localparam int CNT_W   = (MW_BITS > WC_W + 1) ? MW_BITS : WC_W + 1;
  localparam int ACC_CW  = ((ADC_BITS > SUM_W) ? ADC_BITS : SUM_W) + 1;
  localparam int PROD_W  = SUM_W + GAIN_W;
  localparam int SCL_W   = PROD_W + 1 - FRAC_BITS;

  // config registers
  logic [WS_W-1:0]   window_samples;
  logic [WC_W-1:0]   window_count;
  logic [GAIN_W-1:0] rms_gain;

  // window state
  logic [WS_W-1:0]     sample_index;
  logic [WC_W-1:0]     window_index;
  logic [ADC_BITS-1:0] running_max;
  logic [ADC_BITS-1:0] running_min;
  logic [SUM_W-1:0]    pp_accumulator;

  // hold stage and output stage
  logic             est_valid;
  logic [SUM_W-1:0] est_sum;
  logic             out_valid;
  logic [RMS_W-1:0] out_rms;
  logic [SUM_W-1:0] out_sum;

  logic                take, move;
  logic [ADC_BITS-1:0] max_next, min_next, pp;
  logic [WS_W-1:0]     win_len;
  logic [CNT_W-1:0]    win_cnt;
  logic                win_end, est_end;
  logic [ACC_CW-1:0]   sum_raw;
  logic [SUM_W-1:0]    sum_sat;
  logic [PROD_W-1:0]   product;
  logic [PROD_W:0]     rounded;
  logic [SCL_W-1:0]    scaled;
  logic [RMS_W-1:0]    rms_sat;

  // handshakes
  assign move      = est_valid && (!out_valid || estimate.ready);
  assign adc.ready = !est_valid || !out_valid || estimate.ready;
  assign take      = adc.valid && adc.ready;
  assign cfg.ready = 1'b1;

  assign estimate.valid          = out_valid;
  assign estimate.rms_centivolts = out_rms;
  assign estimate.peak_sum       = out_sum;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples <= WS_RESET;
      window_count   <= WC_RESET;
      rms_gain       <= GAIN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WINDOW_SAMPLES: window_samples <= cfg.data[WS_W-1:0];
        REG_WINDOW_COUNT:   window_count   <= cfg.data[WC_W-1:0];
        REG_RMS_GAIN:       rms_gain       <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // window and estimate limits, zero acts as one, count capped at MAX_WINDOWS
  always_comb begin
    win_len = (window_samples == '0) ? WS_W'(1) : window_samples;
    if (window_count == '0)
      win_cnt = CNT_W'(1);
    else if (CNT_W'(window_count) > CNT_W'(MAX_WINDOWS))
      win_cnt = CNT_W'(MAX_WINDOWS);
    else
      win_cnt = CNT_W'(window_count);
  end

  // min/max tracking and peak-to-peak accumulate
  always_comb begin
    max_next = (adc.sample >= running_max) ? adc.sample : running_max;
    min_next = (adc.sample <= running_min) ? adc.sample : running_min;
    pp       = max_next - min_next;
    win_end  = !(({1'b0, sample_index} + (WS_W+1)'(1)) < {1'b0, win_len});
    est_end  = !((CNT_W'(window_index) + CNT_W'(1)) < win_cnt);
    sum_raw  = ACC_CW'(pp_accumulator) + ACC_CW'(pp);
    sum_sat  = (sum_raw > ACC_CW'(ACC_MAX)) ? ACC_MAX : sum_raw[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index   <= '0;
      window_index   <= '0;
      running_max    <= '0;
      running_min    <= '1;
      pp_accumulator <= '0;
    end else if (take) begin
      if (!win_end) begin
        sample_index <= sample_index + WS_W'(1);
        running_max  <= max_next;
        running_min  <= min_next;
      end else begin
        sample_index <= '0;
        running_max  <= '0;
        running_min  <= '1;
        if (!est_end) begin
          window_index   <= window_index + WC_W'(1);
          pp_accumulator <= sum_sat;
        end else begin
          window_index   <= '0;
          pp_accumulator <= '0;
        end
      end
    end
  end

  // hold register for a finished sum
  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
    end else if (take && win_end && est_end) begin
      est_valid <= 1'b1;
    end else if (move) begin
      est_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && win_end && est_end) begin
      est_sum <= sum_sat;
    end
  end

  // Q16 scaling, round half up, saturate
  always_comb begin
    product = PROD_W'(est_sum) * PROD_W'(rms_gain);
    rounded = {1'b0, product} + (PROD_W+1)'(1 << (FRAC_BITS - 1));
    scaled  = rounded[PROD_W:FRAC_BITS];
    rms_sat = (scaled > SCL_W'(RMS_MAX)) ? RMS_MAX : scaled[RMS_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (estimate.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_rms <= rms_sat;
      out_sum <= est_sum;
    end
  end

endmodule

[sv/arp_checker.sv]
// ----------------------------------------------------------------------------
// arp_checker
// Port-level checks on the peak-to-peak RMS estimator, bound to the top level.
// ----------------------------------------------------------------------------
module arp_checker
  import arp_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             adc_ready,
  input logic             est_valid,
  input logic             est_ready,
  input logic [RMS_W-1:0] est_rms,
  input logic [SUM_W-1:0] est_sum
);

  // a stalled estimate stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    est_valid && !est_ready |=> est_valid)
    else $error("estimate dropped while stalled");

  // a stalled estimate keeps its word
  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    est_valid && !est_ready |=> $stable(est_rms) && $stable(est_sum))
    else $error("estimate word changed while stalled");

  // sample intake stops only behind a stalled estimate
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !adc_ready |-> est_valid && !est_ready)
    else $error("sample intake stalled without output backpressure");

  // a zero sum scales to zero
  a_zero_scale: assert property (@(posedge clk) disable iff (rst)
    est_valid && est_sum == '0 |-> est_rms == '0)
    else $error("nonzero estimate from zero peak sum");

endmodule

bind ac_rms_from_peak_to_peak arp_checker u_arp_checker (
  .clk       (clk),
  .rst       (rst),
  .adc_ready (adc.ready),
  .est_valid (estimate.valid),
  .est_ready (estimate.ready),
  .est_rms   (estimate.rms_centivolts),
  .est_sum   (estimate.peak_sum)
);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the peak-to-peak RMS estimator. A directed script
// hits register extremes, mid-estimate register changes and zero or oversized
// limits. Randomized phases follow, each with its own register setting and
// idling mode. Every accepted sample goes through a local model of the window
// and accumulate logic; estimates are checked in order against it or the script.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import arp_pkg::*;

  localparam int ADC_W      = 10;
  localparam int MAX_WIN    = 16;
  localparam int SETTLE     = 6;     // pipeline is two deep, plus margin
  localparam int QUIET_MAX  = 2000;  // cycles with no word moving on any channel
  localparam int HOLD_LONG  = 40;

  typedef struct packed {
    logic [RMS_W-1:0] rms;
    logic [SUM_W-1:0] sum;
  } estimate_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_CHECKED} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [ADC_W-1:0]      sample;
    estimate_t             want;
  } row_t;

  logic clk;
  logic rst;

  arp_sample_if #(.ADC_BITS(ADC_W)) adc_ch ();
  arp_result_if                     est_ch ();
  arp_cfg_if                        cfg_ch ();

  ac_rms_from_peak_to_peak #(
    .ADC_BITS    (ADC_W),
    .MAX_WINDOWS (MAX_WIN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .adc      (adc_ch),
    .estimate (est_ch),
    .cfg      (cfg_ch)
  );

  // register copies, as the block should hold them
  logic [WS_W-1:0]   len_cfg  = WS_RESET;
  logic [WC_W-1:0]   cnt_cfg  = WC_RESET;
  logic [GAIN_W-1:0] gain_cfg = GAIN_RESET;

  // window tracking state
  logic [WS_W-1:0]  win_pos  = '0;
  logic [WC_W-1:0]  win_done = '0;
  logic [ADC_W-1:0] peak_hi  = '0;
  logic [ADC_W-1:0] peak_lo  = '1;
  logic [SUM_W-1:0] pp_total = '0;

  estimate_t estimates_due[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_len      = 0;
  int mismatches    = 0;
  int sent_count    = 0;
  int seen_count    = 0;
  int quiet         = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // fold one sample into the window state; returns 1 when an estimate is due
  function automatic bit fold_sample(input logic [ADC_W-1:0] s, output estimate_t est);
    int unsigned span;
    int unsigned windows;
    int unsigned total;
    logic [63:0] scaled;
    est     = '0;
    span    = (len_cfg == 0) ? 1 : len_cfg;
    windows = (cnt_cfg == 0) ? 1 : cnt_cfg;
    if (windows > MAX_WIN) windows = MAX_WIN;
    if (s >= peak_hi) peak_hi = s;
    if (s <= peak_lo) peak_lo = s;
    if (win_pos + 1 < span) begin
      win_pos = win_pos + 1'b1;
      return 1'b0;
    end
    // window closes: add its peak-to-peak, saturating
    total = pp_total + (peak_hi - peak_lo);
    if (total > ACC_MAX) total = ACC_MAX;
    pp_total = total[SUM_W-1:0];
    win_pos  = '0;
    peak_hi  = '0;
    peak_lo  = '1;
    if (win_done + 1 < windows) begin
      win_done = win_done + 1'b1;
      return 1'b0;
    end
    // Q16 scale, round half up, saturate
    scaled  = (64'(pp_total) * 64'(gain_cfg) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    est.rms = (scaled > RMS_MAX) ? RMS_MAX : scaled[RMS_W-1:0];
    est.sum = pp_total;
    pp_total = '0;
    win_done = '0;
    return 1'b1;
  endfunction

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch %0d at %0t: %s", mismatches, $realtime, msg);
  endfunction

  // directed script rows
  function automatic row_t wr(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '{kind: ROW_WRITE, idx: idx, data: data, sample: '0, want: '0};
    return r;
  endfunction

  function automatic row_t smp(input logic [ADC_W-1:0] s);
    row_t r;
    r = '{kind: ROW_SAMPLE, idx: REG_WINDOW_SAMPLES, data: '0, sample: s, want: '0};
    return r;
  endfunction

  function automatic row_t chk(input logic [ADC_W-1:0] s, input int rms, input int sum);
    row_t r;
    r = '{kind: ROW_CHECKED, idx: REG_WINDOW_SAMPLES, data: '0, sample: s,
          want: '{rms: RMS_W'(rms), sum: SUM_W'(sum)}};
    return r;
  endfunction

  // offer one sample; leaves valid high after the word is taken
  task automatic send_sample(input logic [ADC_W-1:0] s, input bit typed, input estimate_t want);
    estimate_t est;
    bit        hit;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      adc_ch.valid <= 1'b0;
      @(posedge clk);
    end
    adc_ch.valid  <= 1'b1;
    adc_ch.sample <= s;
    @(posedge clk);
    while (!adc_ch.ready) @(posedge clk);
    hit = fold_sample(s, est);
    if (typed) estimates_due.push_back(want);
    else if (hit) estimates_due.push_back(est);
    sent_count++;
  endtask

  // register write; valid stays high so writes can go back to back
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_WINDOW_SAMPLES: len_cfg  = data[WS_W-1:0];
      REG_WINDOW_COUNT:   cnt_cfg  = data[WC_W-1:0];
      REG_RMS_GAIN:       gain_cfg = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // stop sending, let every estimate drain, then let the pipeline settle
  task automatic wait_drained();
    adc_ch.valid <= 1'b0;
    while (estimates_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one randomized phase: register setting, idling mode, sample stream
  task automatic run_phase(input int n);
    logic [CFG_DATA_W-1:0] ws;
    logic [CFG_DATA_W-1:0] wc;
    logic [CFG_DATA_W-1:0] gn;
    logic [ADC_W-1:0]      s;
    logic [ADC_W-1:0]      center;
    bit                    full_scale;
    int                    items;
    int                    pick;
    full_scale = 1'b0;
    items      = 60;
    ws = {10'($urandom), 8'($urandom_range(0, 10))};
    wc = {13'($urandom), 5'($urandom_range(0, 8))};
    gn = 18'($urandom);
    if ($urandom_range(0, 7) == 0) wc[WC_W-1:0] = 5'($urandom_range(9, 31));
    if ($urandom_range(0, 9) == 0) ws[WS_W-1:0] = 8'($urandom_range(11, 255));
    case (n)
      0: begin
        ws = 18'd255; wc = 18'd1; items = 300;
      end
      1: begin
        ws = 18'd1; wc = 18'd31; gn = '1;
      end
      2: begin
        ws = 18'd4; wc = 18'd16; gn = '1; full_scale = 1'b1; items = 130;
      end
      3: begin
        ws[WS_W-1:0] = '0; wc[WC_W-1:0] = '0;
      end
      default: ;
    endcase

    wait_drained();
    if (n < 4 || $urandom_range(0, 2) != 0) write_reg(REG_WINDOW_SAMPLES, ws);
    if (n < 4 || $urandom_range(0, 2) != 0) write_reg(REG_WINDOW_COUNT, wc);
    if (n < 4 || $urandom_range(0, 2) != 0) write_reg(REG_RMS_GAIN, gn);
    cfg_ch.valid <= 1'b0;

    case (n % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 55; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 55; end
      default: begin send_idle_pct = 36; stall_pct = 36; end
    endcase
    // long output stall while samples keep coming, one estimate per sample
    if (n == 3) hold_len = HOLD_LONG;

    center = ADC_W'($urandom);
    repeat (items) begin
      pick = $urandom_range(0, 9);
      if (full_scale) s = $urandom_range(0, 1) ? '1 : '0;
      else if (pick == 0) s = '0;
      else if (pick == 1) s = '1;
      else if (pick < 4) s = center ^ ADC_W'($urandom_range(0, 15));
      else s = ADC_W'($urandom);
      send_sample(s, 1'b0, '0);
    end
  endtask

  // output ready: random stalls, plus the occasional long hold-off
  initial begin
    est_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        est_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      est_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // estimate checker
  always @(posedge clk) begin
    estimate_t want;
    if (!rst && est_ch.valid && est_ch.ready) begin
      seen_count++;
      if (estimates_due.size() == 0) begin
        flag($sformatf("unexpected estimate rms=%0d sum=%0d",
                       est_ch.rms_centivolts, est_ch.peak_sum));
      end else begin
        want = estimates_due.pop_front();
        if (est_ch.rms_centivolts !== want.rms)
          flag($sformatf("rms_centivolts expected %0d got %0d", want.rms, est_ch.rms_centivolts));
        if (est_ch.peak_sum !== want.sum)
          flag($sformatf("peak_sum expected %0d got %0d", want.sum, est_ch.peak_sum));
      end
    end
  end

  // watchdog: no word moving on any channel for too long
  always @(posedge clk) begin
    if (rst || (adc_ch.valid && adc_ch.ready) || (est_ch.valid && est_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  // main sequence
  initial begin
    row_t script[$];
    bit   cfg_open;
    int   n;
    cfg_open = 1'b0;
    n        = 0;
    rst           <= 1'b1;
    adc_ch.valid  <= 1'b0;
    adc_ch.sample <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_WINDOW_SAMPLES;
    cfg_ch.data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    script = '{
      // partial window at reset setting, then shorten window and count under it
      smp(100), smp(900), smp(37),
      wr(REG_WINDOW_SAMPLES, 18'd2), wr(REG_WINDOW_COUNT, 18'd1),
      smp(500),
      // unity gain, full-scale swing
      wr(REG_RMS_GAIN, 18'd65536), smp(0), chk(1023, 1023, 1023),
      // zero gain
      wr(REG_RMS_GAIN, 18'd0), smp(1023), chk(0, 0, 1023),
      // largest gain
      wr(REG_RMS_GAIN, 18'h3FFFF), smp(0), smp(1023),
      // zero window length and zero count both act as one
      wr(REG_WINDOW_SAMPLES, 18'd0), wr(REG_WINDOW_COUNT, 18'd0),
      wr(REG_RMS_GAIN, 18'd65536), chk(512, 0, 0), chk(1023, 0, 0),
      // upper data bits beyond each register are dropped
      wr(REG_WINDOW_SAMPLES, 18'h3FF03), wr(REG_WINDOW_COUNT, 18'h3FFE2),
      smp(0), smp(1023), smp(512), smp(1023), smp(1023), chk(1023, 1023, 1023)
    };

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (!cfg_open) wait_drained();
        write_reg(script[i].idx, script[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_ch.valid <= 1'b0;
        cfg_open = 1'b0;
        send_sample(script[i].sample, script[i].kind == ROW_CHECKED, script[i].want);
      end
    end

    while (sent_count < 750 || seen_count < 48) begin
      run_phase(n);
      n++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
